[rtl/pmg_pkg.sv]
// ============================================================================
// pmg_pkg - shared types and constants of the prefix glob matcher
// Holds the item mode codes, the special characters and the control bundle
// that the top level hands to the slot bank.
// ============================================================================
package pmg_pkg;

    // Item modes
    localparam logic [1:0] MODE_WRITE_CHAR = 2'd0;
    localparam logic [1:0] MODE_SET_LEN    = 2'd1;
    localparam logic [1:0] MODE_NAME_BYTE  = 2'd2;
    localparam logic [1:0] MODE_NAME_END   = 2'd3;

    // Characters with a special meaning in a pattern
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One-cycle strobes and operands from the sequencer to the slot bank.
    typedef struct packed {
        logic       set_len;
        logic       step;
        logic       finish;
        logic [3:0] slot;
        logic [6:0] len;
        logic [7:0] byte_val;
    } slot_ctrl_t;

    // '.' and '/' compare as equal to each other.
    function automatic logic chars_equal(input logic [7:0] p, input logic [7:0] c);
        logic eq;
        eq = (p == c)
            || ((p == CH_DOT) && (c == CH_SLASH))
            || ((p == CH_SLASH) && (c == CH_DOT));
        return eq;
    endfunction

endpackage

[rtl/pmg_ram.sv]
// ============================================================================
// pmg_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module pmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/pmg_slot_bank.sv]
// ============================================================================
// pmg_slot_bank - per-slot lengths, match flags and comparators
// Compares every slot in parallel against one row of pattern text and
// combines the end-of-name verdicts into a single hit bit.
// ============================================================================
module pmg_slot_bank
    import pmg_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int MAX_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slot_ctrl_t                    ctrl,
    input  logic [$clog2(MAX_LEN+2)-1:0]  count,
    input  logic [SLOTS*8-1:0]            row,
    output logic                          any_hit
);

    localparam int LW = $clog2(MAX_LEN + 1);

    logic [LW-1:0]    len_reg [SLOTS];
    logic [SLOTS-1:0] mismatch_reg;
    logic [SLOTS-1:0] star_reg;
    logic [LW-1:0]    sat_len;

    assign sat_len = (32'(ctrl.len) > MAX_LEN) ? LW'(MAX_LEN) : LW'(ctrl.len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                len_reg[s] <= '0;
            end
            mismatch_reg <= '0;
            star_reg     <= '0;
        end
        else
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (ctrl.set_len && (32'(ctrl.slot) == s))
                begin
                    len_reg[s] <= sat_len;
                end
                if (ctrl.finish)
                begin
                    mismatch_reg[s] <= 1'b0;
                    star_reg[s]     <= 1'b0;
                end
                else if (ctrl.step && !star_reg[s] && !mismatch_reg[s]
                         && (32'(count) < 32'(len_reg[s])))
                begin
                    if (row[s*8 +: 8] == CH_STAR)
                    begin
                        star_reg[s] <= 1'b1;
                    end
                    else if (!chars_equal(row[s*8 +: 8], ctrl.byte_val))
                    begin
                        mismatch_reg[s] <= 1'b1;
                    end
                end
            end
        end
    end

    // A pattern that ends in '*' right after the name's last byte still
    // matches; the row then holds the character at the name length.
    always_comb
    begin
        any_hit = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if ((len_reg[s] != '0) && !mismatch_reg[s]
                && !(32'(count) + 1 < 32'(len_reg[s])))
            begin
                if (star_reg[s] || (32'(count) == 32'(len_reg[s])))
                begin
                    any_hit = 1'b1;
                end
                else if ((32'(count) + 1 == 32'(len_reg[s])) && (row[s*8 +: 8] == CH_STAR))
                begin
                    any_hit = 1'b1;
                end
            end
        end
    end

    // Flags never change in a cycle that neither steps nor finishes.
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.step && !ctrl.finish) |=> ($stable(mismatch_reg) && $stable(star_reg)))
        else $error("slot flags changed without a name transfer");

    // A finished name leaves every flag clear.
    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> ((mismatch_reg == '0) && (star_reg == '0)))
        else $error("slot flags not cleared at end of name");

    // A slot never holds both a mismatch and a star.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (mismatch_reg & star_reg) == '0)
        else $error("slot both mismatched and starred");

endmodule

[rtl/multi_pattern_prefix_glob_matcher_unit.sv]
// ============================================================================
// multi_pattern_prefix_glob_matcher_unit - prefix glob name matcher
// Loads up to SLOTS patterns into a text memory and streams names past
// them, reporting at each end of name whether any loaded pattern matched.
// ============================================================================
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------
//  in      | input     | in_valid/in_stall  | mode, slot, char_pos, byte_value,
//          |           |                    | pattern_len
//  out     | output    | out_valid/out_stall| matched
//
//  Each input transfer has an accept cycle, which issues the read of one
//  pattern-text row, and an execute cycle, which uses the registered row.
//  An end of name waits in the execute cycle for as long as a previous result
//  is still held on the output and stalled.
//  Reset clears lengths, flags and the name position at once; pattern text
//  is undefined until written and has no clearing pass.
//  The output register lets a result wait while new items are accepted.
//
module multi_pattern_prefix_glob_matcher_unit
    import pmg_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [3:0] slot,
    input  logic [5:0] char_pos,
    input  logic [7:0] byte_value,
    input  logic [6:0] pattern_len,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched
);

    // Text memory: one row per character position, one byte lane per slot,
    // so that a single read serves every slot's comparator.
    localparam int AW        = $clog2(MAX_LEN);
    localparam int CW        = $clog2(MAX_LEN + 2);
    localparam int ROW_W     = SLOTS * 8;
    localparam int COUNT_CAP = MAX_LEN + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             matched_reg, matched_next;

    // Item held for the execute cycle
    logic [1:0]       mode_reg;
    logic [3:0]       slot_reg;
    logic [7:0]       byte_reg;
    logic [6:0]       len_reg;
    logic             wr_ok_reg;
    logic [AW-1:0]    addr_reg;

    logic             accept;
    logic [AW-1:0]    in_addr;
    logic [AW-1:0]    raddr;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] merged_row;
    logic             ram_we;
    logic             out_free;
    logic             any_hit;
    slot_ctrl_t       ctrl;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Pattern writes address the character position; name items address the
    // current name position. Out-of-range positions read a row nobody uses.
    assign in_addr = (mode == MODE_WRITE_CHAR) ? AW'(char_pos) : AW'(count_reg);
    assign raddr   = (state_reg == ST_IDLE) ? in_addr : addr_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            slot_reg  <= slot;
            byte_reg  <= byte_value;
            len_reg   <= pattern_len;
            wr_ok_reg <= (32'(char_pos) < MAX_LEN) && (32'(slot) < SLOTS);
            addr_reg  <= in_addr;
        end
    end

    // A character write replaces one byte lane of the row just read.
    always_comb
    begin
        merged_row = row;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (32'(slot_reg) == s)
            begin
                merged_row[s*8 +: 8] = byte_reg;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        matched_next   = matched_reg;
        ram_we         = 1'b0;
        ctrl           = '0;
        ctrl.slot      = slot_reg;
        ctrl.len       = len_reg;
        ctrl.byte_val  = byte_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_WRITE_CHAR:
                    begin
                        ram_we     = wr_ok_reg;
                        state_next = ST_IDLE;
                    end
                    MODE_SET_LEN:
                    begin
                        ctrl.set_len = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    MODE_NAME_BYTE:
                    begin
                        ctrl.step = 1'b1;
                        if (32'(count_reg) < COUNT_CAP)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        state_next = ST_IDLE;
                    end
                    MODE_NAME_END:
                    begin
                        // Hold here until the output register can take the bit.
                        if (out_free)
                        begin
                            ctrl.finish    = 1'b1;
                            matched_next   = any_hit;
                            out_valid_next = 1'b1;
                            count_next     = '0;
                            state_next     = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

    pmg_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_LEN)
    ) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (merged_row),
        .raddr (raddr),
        .rdata (row)
    );

    pmg_slot_bank #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) u_slot_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .count   (count_reg),
        .row     (row),
        .any_hit (any_hit)
    );

    // A new result appears only out of the execute cycle of an end of name.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC && mode_reg == MODE_NAME_END))
        else $error("result raised without an end of name");

    // The name position never passes its saturation value.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= COUNT_CAP)
        else $error("name position beyond saturation");

    // Delivering an end of name restarts the name position.
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && mode_reg == MODE_NAME_END && out_free) |=> (count_reg == '0))
        else $error("name position not cleared after end of name");

    // The text memory is written only in the execute cycle of a character write.
    a_we_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXEC && mode_reg == MODE_WRITE_CHAR))
        else $error("text memory written outside a character write");

endmodule
